// ----- rtl/b64_pkg.sv -----
package b64_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef struct packed {
    logic [23:0] bytes;
    logic [2:0]  nsym;
    logic [2:0]  nch;
    logic        last;
  } b64_grp_t;

  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ----- rtl/base64_stream_encoder.sv -----
// A completed or flushed group goes through the group queue and the back end's
// current-group register before its first character reaches the output register.
// Throughput: one input transaction per cycle while the group queue has room;
// the back end sends one character per cycle while out_ready is high; 3 bytes make 4 characters.
// Reset (rst_n low, synchronous): clears held bytes, queue and output; padding on.
module base64_stream_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_carries_byte,
  input  logic       in_end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last_char
);

  b64_pkg::b64_grp_t push_grp, head;
  logic push, pop, q_full, q_empty;

  b64_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_carries_byte   (in_carries_byte),
    .in_end_of_message (in_end_of_message),
    .q_full            (q_full),
    .push              (push),
    .push_grp          (push_grp)
  );

  b64_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .full     (q_full),
    .empty    (q_empty),
    .pop      (pop),
    .head     (head)
  );

  b64_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .out_last_char (out_last_char)
  );

endmodule

// ----- rtl/b64_front.sv -----
module b64_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_carries_byte,
  input  logic               in_end_of_message,
  input  logic               q_full,
  output logic               push,
  output b64_pkg::b64_grp_t  push_grp
);

  logic [15:0] held_r, held_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        pad_r;
  logic        acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && !q_full;

  always_comb begin
    held_nxt = held_r;
    cnt_nxt  = cnt_r;
    push     = 1'b0;
    push_grp = '0;
    if (acc) begin
      if (in_carries_byte && cnt_r == 2'd2) begin
        push          = 1'b1;
        push_grp.bytes = {held_r, in_data_byte};
        push_grp.nsym  = 3'd4;
        push_grp.nch   = 3'd4;
        push_grp.last  = in_end_of_message;
        held_nxt       = '0;
        cnt_nxt        = 2'd0;
      end else if (in_end_of_message) begin
        push_grp.last = 1'b1;
        push_grp.nch  = pad_r ? 3'd4 : 3'd0;
        if (in_carries_byte) begin
          push = 1'b1;
          if (cnt_r == 2'd0) begin
            push_grp.bytes = {in_data_byte, 16'h0000};
            push_grp.nsym  = 3'd2;
          end else begin
            push_grp.bytes = {held_r[15:8], in_data_byte, 8'h00};
            push_grp.nsym  = 3'd3;
          end
        end else begin
          push           = (cnt_r != 2'd0);
          push_grp.bytes = {held_r, 8'h00};
          push_grp.nsym  = {1'b0, cnt_r} + 3'd1;
        end
        if (!pad_r) begin
          push_grp.nch = push_grp.nsym;
        end
        held_nxt = '0;
        cnt_nxt  = 2'd0;
      end else if (in_carries_byte) begin
        if (cnt_r == 2'd1) begin
          held_nxt = {held_r[15:8], in_data_byte};
          cnt_nxt  = 2'd2;
        end else begin
          held_nxt = {in_data_byte, 8'h00};
          cnt_nxt  = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      cnt_r  <= 2'd0;
      pad_r  <= 1'b1;
    end else begin
      held_r <= held_nxt;
      cnt_r  <= cnt_nxt;
      if (cfg_we) begin
        pad_r <= cfg_wdata;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("held count out of range");

endmodule

// ----- rtl/b64_queue.sv -----
module b64_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  b64_pkg::b64_grp_t  push_grp,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output b64_pkg::b64_grp_t  head
);

  b64_pkg::b64_grp_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
    else $error("pop from empty queue");

endmodule

// ----- rtl/b64_back.sv -----
module b64_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  b64_pkg::b64_grp_t  head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_char,
  output logic               out_last_char
);

  b64_pkg::b64_grp_t cur_r;
  logic        cur_valid_r;
  logic [1:0]  idx_r;
  logic        out_valid_r;
  logic [7:0]  out_char_r;
  logic        out_last_r;
  logic        slot_free, emit, final_ch;
  logic [5:0]  sextet;
  logic [7:0]  ch;

  assign slot_free = !out_valid_r || out_ready;
  assign emit      = cur_valid_r && slot_free;
  assign final_ch  = ({1'b0, idx_r} == cur_r.nch - 3'd1);
  assign pop       = !q_empty && (!cur_valid_r || (emit && final_ch));

  always_comb begin
    case (idx_r)
      2'd0:    sextet = cur_r.bytes[23:18];
      2'd1:    sextet = cur_r.bytes[17:12];
      2'd2:    sextet = cur_r.bytes[11:6];
      default: sextet = cur_r.bytes[5:0];
    endcase
    ch = ({1'b0, idx_r} < cur_r.nsym) ? b64_pkg::sym(sextet) : b64_pkg::PAD_CHAR;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
    if (emit) begin
      out_char_r <= ch;
      out_last_r <= cur_r.last && final_ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid_r <= 1'b1;
        idx_r       <= 2'd0;
      end else if (emit) begin
        if (final_ch) begin
          cur_valid_r <= 1'b0;
        end
        idx_r <= idx_r + 2'd1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_last_char = out_last_r;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> ({1'b0, idx_r} < cur_r.nch))
    else $error("character index past group length");
  a_nch_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cur_r.nch >= 3'd2 && cur_r.nch <= 3'd4 && cur_r.nsym <= cur_r.nch))
    else $error("bad group length");

endmodule
